>>> sv/hslp_pkg.sv
package hslp_pkg;

   // Width of the line offset counter; it saturates at its top value
   localparam int OFFSET_BITS = 12;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   // Field widths of one result word
   localparam int RESULT_BITS = 2;
   localparam int STATUS_BITS = 10;
   localparam int OUT_OFFSET_BITS = 12;

   // Result codes
   localparam logic [RESULT_BITS-1:0] RES_AGAIN = 2'd0;
   localparam logic [RESULT_BITS-1:0] RES_DONE = 2'd1;
   localparam logic [RESULT_BITS-1:0] RES_BAD = 2'd2;

   // Characters the parser looks for
   localparam logic [7:0] CH_H = 8'h48;
   localparam logic [7:0] CH_T = 8'h54;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Number of status digits
   localparam logic [1:0] STATUS_DIGITS = 2'd3;

   // One result word as produced by the parser
   typedef struct packed {
      logic [RESULT_BITS-1:0]     result_code;
      logic [STATUS_BITS-1:0]     status_code;
      logic [OUT_OFFSET_BITS-1:0] code_start_offset;
      logic [OUT_OFFSET_BITS-1:0] text_end_offset;
   } result_type;

endpackage

>>> sv/hslp_parser.sv
module hslp_parser
   import hslp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] byte_value,
   output result_type result
);

   typedef enum logic [3:0] {
      PH_START,
      PH_H,
      PH_HT,
      PH_HTT,
      PH_HTTP,
      PH_MAJ_FIRST,
      PH_MAJ,
      PH_MIN_FIRST,
      PH_MIN,
      PH_STATUS,
      PH_AFTER_STATUS,
      PH_TEXT,
      PH_ALMOST
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [STATUS_BITS-1:0] acc_ff, acc_in;
   logic [1:0]             digit_cnt_ff, digit_cnt_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] code_start_ff, code_start_in;
   logic [OFFSET_BITS-1:0] text_end_ff, text_end_in;
   logic                   text_end_seen_ff, text_end_seen_in;

   logic                   bad, done, is_digit;
   logic [3:0]             digit;
   logic [13:0]            acc_sum;
   logic [OFFSET_BITS-1:0] text_end_out;

   // Character classes and the decimal accumulate step
   assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
   assign digit = 4'(byte_value - CH_ZERO);
   assign acc_sum = 14'(acc_ff) * 14'd10 + 14'(digit);

   // Phase transitions and next state
   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      digit_cnt_in = digit_cnt_ff;
      code_start_in = code_start_ff;
      text_end_in = text_end_ff;
      text_end_seen_in = text_end_seen_ff;
      bad = 1'b0;
      done = 1'b0;
      offset_in = (offset_ff != OFFSET_MAX) ? offset_ff + 1'b1 : offset_ff;

      case (phase_ff)
         PH_START: begin
            if (byte_value == CH_H) phase_in = PH_H; else bad = 1'b1;
         end
         PH_H: begin
            if (byte_value == CH_T) phase_in = PH_HT; else bad = 1'b1;
         end
         PH_HT: begin
            if (byte_value == CH_T) phase_in = PH_HTT; else bad = 1'b1;
         end
         PH_HTT: begin
            if (byte_value == CH_P) phase_in = PH_HTTP; else bad = 1'b1;
         end
         PH_HTTP: begin
            if (byte_value == CH_SLASH) phase_in = PH_MAJ_FIRST; else bad = 1'b1;
         end
         PH_MAJ_FIRST: begin
            if (byte_value >= CH_ONE && byte_value <= CH_NINE) phase_in = PH_MAJ;
            else bad = 1'b1;
         end
         PH_MAJ: begin
            if (byte_value == CH_DOT) phase_in = PH_MIN_FIRST;
            else if (!is_digit) bad = 1'b1;
         end
         PH_MIN_FIRST: begin
            if (is_digit) phase_in = PH_MIN; else bad = 1'b1;
         end
         PH_MIN: begin
            if (byte_value == CH_SPACE) phase_in = PH_STATUS;
            else if (!is_digit) bad = 1'b1;
         end
         PH_STATUS: begin
            if (!is_digit) begin
               bad = 1'b1;
            end else begin
               if (digit_cnt_ff == 2'd0) code_start_in = offset_ff;
               acc_in = STATUS_BITS'(acc_sum);
               if (digit_cnt_ff == STATUS_DIGITS - 2'd1) begin
                  digit_cnt_in = 2'd0;
                  phase_in = PH_AFTER_STATUS;
               end else begin
                  digit_cnt_in = digit_cnt_ff + 2'd1;
               end
            end
         end
         PH_AFTER_STATUS: begin
            if (byte_value == CH_SPACE) begin
               phase_in = PH_TEXT;
            end else if (byte_value == CH_CR) begin
               text_end_in = offset_ff;
               text_end_seen_in = 1'b1;
               phase_in = PH_ALMOST;
            end else if (byte_value == CH_LF) begin
               done = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         PH_TEXT: begin
            if (byte_value == CH_CR) begin
               text_end_in = offset_ff;
               text_end_seen_in = 1'b1;
               phase_in = PH_ALMOST;
            end else if (byte_value == CH_LF) begin
               done = 1'b1;
            end
         end
         PH_ALMOST: begin
            if (byte_value == CH_LF) done = 1'b1; else bad = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      // Line finished either way: back to the start of a new line
      if (bad || done) begin
         phase_in = PH_START;
         acc_in = '0;
         digit_cnt_in = 2'd0;
         offset_in = '0;
         code_start_in = '0;
         text_end_in = '0;
         text_end_seen_in = 1'b0;
      end
   end

   // Result word for this byte
   assign text_end_out = text_end_seen_ff ? text_end_ff : offset_ff;

   always_comb begin
      if (bad) begin
         result.result_code = RES_BAD;
         result.status_code = '0;
         result.code_start_offset = '0;
         result.text_end_offset = '0;
      end else if (done) begin
         result.result_code = RES_DONE;
         result.status_code = acc_ff;
         result.code_start_offset = OUT_OFFSET_BITS'(code_start_ff);
         result.text_end_offset = OUT_OFFSET_BITS'(text_end_out);
      end else begin
         result.result_code = RES_AGAIN;
         result.status_code = acc_in;
         result.code_start_offset = '0;
         result.text_end_offset = '0;
      end
   end

   // Parser state, advanced once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         acc_ff <= '0;
         digit_cnt_ff <= 2'd0;
         offset_ff <= '0;
         code_start_ff <= '0;
         text_end_ff <= '0;
         text_end_seen_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         digit_cnt_ff <= digit_cnt_in;
         offset_ff <= offset_in;
         code_start_ff <= code_start_in;
         text_end_ff <= text_end_in;
         text_end_seen_ff <= text_end_seen_in;
      end
   end

`ifndef SYNTHESIS
   // A finished or rejected line leaves the parser at the start of a new line
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      step_en && (result.result_code == RES_DONE || result.result_code == RES_BAD)
      |=> phase_ff == PH_START && offset_ff == '0 && acc_ff == '0
          && !text_end_seen_ff)
      else $error("parser state not cleared after end of line");

   // The digit counter wraps after the third status digit
   a_digit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      digit_cnt_ff != STATUS_DIGITS)
      else $error("status digit counter out of range");

   // No word, no state change
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(offset_ff) && $stable(acc_ff))
      else $error("parser state moved without a word");
`endif

endmodule

>>> sv/http_status_line_parser.sv
// Path: a byte accepted into the input register is parsed and its result word is
// loaded into the result register when that register is free; a stall on the result
// side holds the byte in the input register (input register, then result register).
// Throughput: one byte per cycle while the result side does not stall.
// Reset: synchronous, active high; empties both registers and returns the
// parser to the start of a line with offset zero. No clearing pass is needed.
module http_status_line_parser
   import hslp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_byte_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [RESULT_BITS-1:0]     rsp_result_code,
   output logic [STATUS_BITS-1:0]     rsp_status_code,
   output logic [OUT_OFFSET_BITS-1:0] rsp_code_start_offset,
   output logic [OUT_OFFSET_BITS-1:0] rsp_text_end_offset
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type step_result;
   logic       advance, load_in;

   // Pipeline handshake: a word moves on when the result register is free
   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_in = req_valid && !req_stall;

   assign in_valid_in = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   hslp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .byte_value (byte_ff),
      .result     (step_result)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_in) byte_ff <= req_byte_value;
      if (advance) rsp_ff <= step_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_code = rsp_ff.result_code;
   assign rsp_status_code = rsp_ff.status_code;
   assign rsp_code_start_offset = rsp_ff.code_start_offset;
   assign rsp_text_end_offset = rsp_ff.text_end_offset;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import hslp_pkg::*;

   localparam int RANDOM_WORDS = 850;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 150;

   // Parser phases, kept apart from the RTL encoding
   typedef enum logic [3:0] {
      P_START, P_H, P_HT, P_HTT, P_HTTP, P_MAJ_FIRST, P_MAJ, P_MIN_FIRST, P_MIN,
      P_CODE, P_AFTER_CODE, P_TEXT, P_LF_WAIT
   } phase_type;

   typedef struct {
      logic [7:0] value;
      bit         typed;
      result_type want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_byte_value = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RESULT_BITS-1:0] rsp_result_code;
   logic [STATUS_BITS-1:0] rsp_status_code;
   logic [OUT_OFFSET_BITS-1:0] rsp_code_start_offset;
   logic [OUT_OFFSET_BITS-1:0] rsp_text_end_offset;

   // Side info that travels with each offered word
   bit req_typed = 1'b0;
   result_type req_want = '0;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   // Predictor state
   phase_type cur_phase;
   logic [STATUS_BITS-1:0] code_acc;
   logic [1:0] ndigits;
   logic [OFFSET_BITS-1:0] line_off;
   logic [OFFSET_BITS-1:0] code_start;
   logic [OFFSET_BITS-1:0] text_end;
   bit text_end_seen;

   result_type pending_status[$];
   step_row_type directed_rows[$];
   logic [7:0] line_bytes[$];

   int unsigned mismatch_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned lines_done = 0;
   int unsigned lines_rejected = 0;
   int unsigned words_sent = 0;

   http_status_line_parser uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_code(rsp_result_code),
      .rsp_status_code(rsp_status_code),
      .rsp_code_start_offset(rsp_code_start_offset),
      .rsp_text_end_offset(rsp_text_end_offset)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_line();
      cur_phase = P_START;
      code_acc = '0;
      ndigits = '0;
      line_off = '0;
      code_start = '0;
      text_end = '0;
      text_end_seen = 1'b0;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Advance the line parser by one byte and form its result word
   function automatic result_type parse_status_byte(input logic [7:0] c);
      logic [OFFSET_BITS-1:0] here;
      bit bad;
      bit done;
      result_type r;
      here = line_off;
      bad = 1'b0;
      done = 1'b0;
      if (line_off != OFFSET_MAX) line_off = line_off + 1'b1;
      case (cur_phase)
         P_START: if (c == CH_H) cur_phase = P_H; else bad = 1'b1;
         P_H: if (c == CH_T) cur_phase = P_HT; else bad = 1'b1;
         P_HT: if (c == CH_T) cur_phase = P_HTT; else bad = 1'b1;
         P_HTT: if (c == CH_P) cur_phase = P_HTTP; else bad = 1'b1;
         P_HTTP: if (c == CH_SLASH) cur_phase = P_MAJ_FIRST; else bad = 1'b1;
         P_MAJ_FIRST: if (c >= CH_ONE && c <= CH_NINE) cur_phase = P_MAJ; else bad = 1'b1;
         P_MAJ: begin
            if (c == CH_DOT) cur_phase = P_MIN_FIRST;
            else if (!is_digit(c)) bad = 1'b1;
         end
         P_MIN_FIRST: if (is_digit(c)) cur_phase = P_MIN; else bad = 1'b1;
         P_MIN: begin
            if (c == CH_SPACE) cur_phase = P_CODE;
            else if (!is_digit(c)) bad = 1'b1;
         end
         P_CODE: begin
            if (!is_digit(c)) begin
               bad = 1'b1;
            end else begin
               if (ndigits == 2'd0) code_start = here;
               code_acc = STATUS_BITS'(code_acc * 10 + (c - CH_ZERO));
               ndigits = ndigits + 1'b1;
               if (ndigits == STATUS_DIGITS) begin
                  ndigits = '0;
                  cur_phase = P_AFTER_CODE;
               end
            end
         end
         P_AFTER_CODE: begin
            if (c == CH_SPACE) begin
               cur_phase = P_TEXT;
            end else if (c == CH_CR) begin
               text_end = here;
               text_end_seen = 1'b1;
               cur_phase = P_LF_WAIT;
            end else if (c == CH_LF) begin
               done = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         P_TEXT: begin
            if (c == CH_CR) begin
               text_end = here;
               text_end_seen = 1'b1;
               cur_phase = P_LF_WAIT;
            end else if (c == CH_LF) begin
               done = 1'b1;
            end
         end
         P_LF_WAIT: if (c == CH_LF) done = 1'b1; else bad = 1'b1;
         default: bad = 1'b1;
      endcase

      if (bad) begin
         r = '{RES_BAD, '0, '0, '0};
         clear_line();
      end else if (done) begin
         if (!text_end_seen) text_end = here;
         r = '{RES_DONE, code_acc, code_start, text_end};
         clear_line();
      end else begin
         r = '{RES_AGAIN, code_acc, '0, '0};
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: %s got %0d expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Predict on accepted bytes, check accepted result words
   always @(posedge clock) begin
      result_type want;
      result_type pred;
      if (reset) begin
         clear_line();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_status.size() == 0) begin
               report_mismatch("unexpected word, result_code", rsp_result_code, 0);
            end else begin
               want = pending_status.pop_front();
               if (rsp_result_code != want.result_code)
                  report_mismatch("result_code", rsp_result_code, want.result_code);
               if (rsp_status_code != want.status_code)
                  report_mismatch("status_code", rsp_status_code, want.status_code);
               if (rsp_code_start_offset != want.code_start_offset)
                  report_mismatch("code_start_offset", rsp_code_start_offset,
                                  want.code_start_offset);
               if (rsp_text_end_offset != want.text_end_offset)
                  report_mismatch("text_end_offset", rsp_text_end_offset,
                                  want.text_end_offset);
               if (rsp_result_code == RES_DONE) lines_done++;
               if (rsp_result_code == RES_BAD) lines_rejected++;
            end
         end
         if (req_valid && !req_stall) begin
            pred = parse_status_byte(req_byte_value);
            pending_status.push_back(req_typed ? req_want : pred);
            bytes_accepted++;
         end
      end
   end

   // Receiver: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 19);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_word(input logic [7:0] value, input bit typed, input result_type want);
      while (req_idle_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      req_typed <= typed;
      req_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic add_row(input logic [7:0] value, input bit typed, input result_type want);
      step_row_type row;
      row.value = value;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, '0);
   endtask

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
      return b;
   endfunction

   // Well-formed status line with random versions, code and text
   task automatic build_status_line(input int text_len, input bit use_crlf);
      line_bytes.delete();
      line_bytes = '{CH_H, CH_T, CH_T, CH_P, CH_SLASH};
      line_bytes.push_back(CH_ONE + 8'($urandom_range(8)));
      repeat ($urandom_range(2)) line_bytes.push_back(rand_digit());
      line_bytes.push_back(CH_DOT);
      repeat ($urandom_range(3, 1)) line_bytes.push_back(rand_digit());
      line_bytes.push_back(CH_SPACE);
      repeat (3) line_bytes.push_back(rand_digit());
      if (text_len >= 0) begin
         line_bytes.push_back(CH_SPACE);
         repeat (text_len) line_bytes.push_back(rand_text_byte());
      end
      if (use_crlf) line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) offer_word(line_bytes[i], 1'b0, '0);
   endtask

   initial begin
      int kind;
      int pos;
      bit hold_done;
      bit pause_done;

      // Directed rows: extremes, a full line without text, a bad major version
      add_row(8'hFF, 1'b1, '{RES_BAD, '0, '0, '0});
      add_row(8'h00, 1'b1, '{RES_BAD, '0, '0, '0});
      add_row(CH_H, 1'b1, '{RES_AGAIN, '0, '0, '0});
      add_text("TTP/9.0 999");
      add_row(CH_LF, 1'b1, '{RES_DONE, 10'd999, 12'd9, 12'd12});
      add_text("HTTP/");
      add_row(CH_ZERO, 1'b1, '{RES_BAD, '0, '0, '0});

      hold_done = 1'b0;
      pause_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_word(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

      // Random lines: mostly well formed, the rest corrupted or noise
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         req_idle_on = !(words_sent >= 300 && words_sent < 450);
         rsp_idle_on = req_idle_on;
         if (!hold_done && words_sent >= 500) begin
            long_hold_req = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && words_sent >= 650) begin
            req_valid <= 1'b0;
            while (pending_status.size() != 0) @(posedge clock);
            pause_done = 1'b1;
         end
         kind = $urandom_range(99);
         build_status_line($urandom_range(4) == 0 ? -1 : int'($urandom_range(12)),
                           $urandom_range(1));
         if (kind >= 75 && kind < 87) begin
            // one byte replaced anywhere in the line
            pos = $urandom_range(line_bytes.size() - 1);
            line_bytes[pos] = 8'($urandom_range(255));
         end else if (kind >= 87 && kind < 93) begin
            // CR followed by something other than LF
            build_status_line($urandom_range(6), 1'b1);
            do line_bytes[line_bytes.size() - 1] = 8'($urandom_range(255));
            while (line_bytes[line_bytes.size() - 1] == CH_LF);
         end else if (kind >= 93) begin
            line_bytes.delete();
            repeat ($urandom_range(6, 1)) line_bytes.push_back(8'($urandom_range(255)));
         end
         send_line();
      end

      // A clean line to close the stream
      build_status_line($urandom_range(8), 1'b1);
      send_line();
      req_valid <= 1'b0;

      while (pending_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d bytes: %0d status lines complete, %0d rejected,",
               bytes_accepted, lines_done, lines_rejected);
      $display("including a long receiver hold and a pause that drained all words.");
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> http_status_line_parser.f
sv/hslp_pkg.sv
sv/hslp_parser.sv
sv/http_status_line_parser.sv
bench/tb.sv
